@@ design/sdew_pkg.sv @@
`default_nettype none

package sdew_pkg;

  // Wheel and store geometry
  localparam int WHEEL_SLOTS = 32;
  localparam int ENTRY_COUNT = 1024;
  localparam int SLOT_W      = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int ENTRY_AW    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  // Room for pointer plus one wheel turn plus two 5-bit operands
  localparam int SUM_W       = $clog2(2 * WHEEL_SLOTS + 64) + 1;

  // Operation codes
  localparam logic [2:0] OP_ADD_LOCAL = 3'd0;
  localparam logic [2:0] OP_ADD_DELAY = 3'd1;
  localparam logic [2:0] OP_CHECK     = 3'd2;
  localparam logic [2:0] OP_CHECK_DLY = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_ADVANCE   = 3'd5;

  typedef logic [WHEEL_SLOTS-1:0] mask_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [9:0] entry_index;
    logic [7:0] target_cluster;
    logic [4:0] delay_steps;
    logic [4:0] step_offset;
  } sdew_in_t;

  typedef struct packed {
    logic       event_found;
    logic       forwarded;
    logic [9:0] fwd_entry_index;
    logic [7:0] fwd_cluster;
    logic [4:0] fwd_offset;
    logic       collision;
    logic       range_error;
  } sdew_out_t;

  // Update request from the execute stage
  typedef struct packed {
    logic  wr_en;
    mask_t wr_data;
    logic  ptr_en;
    slot_t ptr_nxt;
  } sdew_upd_t;

  // Subtract one wheel turn where the sum has passed it
  function automatic slot_t wrap_once(input sum_t v);
    sum_t r;
    r = (v >= sum_t'(WHEEL_SLOTS)) ? v - sum_t'(WHEEL_SLOTS) : v;
    return r[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/sdew_ram.sv @@
`default_nettype none

module sdew_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port; read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/sdew_exec.sv @@
`default_nettype none

module sdew_exec
  import sdew_pkg::*;
(
  input  wire sdew_in_t   item,
  input  wire mask_t      mask_in,
  input  wire slot_t      cur_slot,
  input  wire logic [7:0] own_cluster,
  output sdew_upd_t       upd,
  output sdew_out_t       res
);

  logic  entry_ok;
  sum_t  cur_x;
  sum_t  dly_x;
  sum_t  off_x;
  slot_t pos_now;
  slot_t pos_fut;
  slot_t pos_past;
  mask_t bit_now;
  mask_t bit_fut;
  mask_t bit_past;
  logic  off_bad;

  // Slot positions for each kind of access
  always_comb begin
    entry_ok = 32'(item.entry_index) < 32'(ENTRY_COUNT);
    cur_x    = sum_t'(cur_slot);
    dly_x    = sum_t'(item.delay_steps);
    off_x    = sum_t'(item.step_offset);
    off_bad  = off_x >= sum_t'(WHEEL_SLOTS);
    pos_now  = wrap_once(cur_x + off_x);
    pos_fut  = wrap_once(cur_x + dly_x + off_x);
    pos_past = wrap_once(cur_x + sum_t'(WHEEL_SLOTS) - (dly_x - off_x));
    bit_now  = mask_t'(1) << pos_now;
    bit_fut  = mask_t'(1) << pos_fut;
    bit_past = mask_t'(1) << pos_past;
  end

  // Decode, check ranges and modify the mask
  always_comb begin
    upd     = '0;
    res     = '0;
    upd.ptr_nxt = cur_slot;
    unique case (item.operation)
      OP_ADD_LOCAL: begin
        if (item.target_cluster != own_cluster) begin
          res.forwarded       = 1'b1;
          res.fwd_entry_index = item.entry_index;
          res.fwd_cluster     = item.target_cluster;
          res.fwd_offset      = item.step_offset;
        end else if (!entry_ok || off_bad) begin
          res.range_error = 1'b1;
        end else begin
          res.collision = |(mask_in & bit_now);
          upd.wr_en     = 1'b1;
          upd.wr_data   = mask_in | bit_now;
        end
      end
      OP_ADD_DELAY: begin
        if (!entry_ok || (dly_x + off_x) >= sum_t'(WHEEL_SLOTS)) begin
          res.range_error = 1'b1;
        end else begin
          res.collision = |(mask_in & bit_fut);
          upd.wr_en     = 1'b1;
          upd.wr_data   = mask_in | bit_fut;
        end
      end
      OP_CHECK: begin
        if (!entry_ok || off_bad) begin
          res.range_error = 1'b1;
        end else begin
          res.event_found = |(mask_in & bit_now);
          upd.wr_en       = 1'b1;
          upd.wr_data     = mask_in & ~bit_now;
        end
      end
      OP_CHECK_DLY: begin
        if (!entry_ok || dly_x <= off_x || dly_x >= sum_t'(WHEEL_SLOTS)) begin
          res.range_error = 1'b1;
        end else begin
          res.event_found = |(mask_in & bit_past);
          upd.wr_en       = 1'b1;
          upd.wr_data     = mask_in & ~bit_past;
        end
      end
      OP_CLEAR: begin
        if (!entry_ok) begin
          res.range_error = 1'b1;
        end else begin
          upd.wr_en   = 1'b1;
          upd.wr_data = '0;
        end
      end
      OP_ADVANCE: begin
        if (off_bad) begin
          res.range_error = 1'b1;
        end else begin
          upd.ptr_en  = 1'b1;
          upd.ptr_nxt = pos_now;
        end
      end
      default: begin
        // unused codes: no change, all flags low
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/synaptic_delay_event_wheel.sv @@
`default_nettype none

// Per-entry bitmap delay wheel for spike events.
// Input: present a transaction on in_data with start high; it is taken at a
// rising edge where busy is low. Result: out_data is shown for exactly one
// cycle with out_valid high, once the transaction has passed the execute
// stage register and the output register. Every accepted transaction gives one
// result; the receiver cannot hold it off.
// Throughput: one transaction per cycle while busy is low. Each transaction
// reads its mask from the single-port-read entry memory in the accept cycle
// and writes it back in the next; a back-to-back access to the same entry
// takes the pending write data through a bypass path.
// Configuration: cfg_we writes own_cluster from cfg_wdata; write only while
// no transaction is in flight. It is accepted at any time, also during clear.
// Reset: rst_n low clears the slot pointer and own_cluster, then a
// clearing pass writes zero to every entry, one per cycle; busy stays high
// until it ends.
module synaptic_delay_event_wheel
  import sdew_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire sdew_in_t   in_data,
  output logic            out_valid,
  output sdew_out_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic                clearing_r;
  logic [ENTRY_AW-1:0] clr_addr_r;
  logic [7:0]          own_cluster_r;
  slot_t               cur_slot_r;
  logic                s1_valid_r;
  sdew_in_t            s1_item_r;
  logic                byp_valid_r;
  logic [ENTRY_AW-1:0] byp_addr_r;
  mask_t               byp_data_r;
  logic                out_valid_r;
  sdew_out_t           out_data_r;

  logic                accept;
  logic [ENTRY_AW-1:0] s1_addr;
  mask_t               rd_data;
  mask_t               mask_cur;
  sdew_upd_t           upd;
  sdew_out_t           res;
  logic                ram_we;
  logic [ENTRY_AW-1:0] ram_waddr;
  mask_t               ram_wdata;

  assign accept  = start && !busy;
  assign busy    = clearing_r;
  assign s1_addr = s1_item_r.entry_index[ENTRY_AW-1:0];

  // Take the last write to the same entry in place of stale read data
  assign mask_cur = (byp_valid_r && byp_addr_r == s1_addr) ? byp_data_r : rd_data;

  // Memory write: clearing pass or execute write-back
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r && upd.wr_en;
      ram_waddr = s1_addr;
      ram_wdata = upd.wr_data;
    end
  end

  sdew_ram #(
    .DATA_W (WHEEL_SLOTS),
    .DEPTH  (ENTRY_COUNT),
    .ADDR_W (ENTRY_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (in_data.entry_index[ENTRY_AW-1:0]),
    .rd_data (rd_data)
  );

  sdew_exec u_exec (
    .item        (s1_item_r),
    .mask_in     (mask_cur),
    .cur_slot    (cur_slot_r),
    .own_cluster (own_cluster_r),
    .upd         (upd),
    .res         (res)
  );

  // Sweep the memory to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (32'(clr_addr_r) == ENTRY_COUNT - 1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_cluster_r <= '0;
    end else if (cfg_we) begin
      own_cluster_r <= cfg_wdata;
    end
  end

  // Advance the slot pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_slot_r <= '0;
    end else if (s1_valid_r && upd.ptr_en) begin
      cur_slot_r <= upd.ptr_nxt;
    end
  end

  // Execute stage and bypass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      byp_valid_r <= s1_valid_r && upd.wr_en;
      out_valid_r <= s1_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    byp_addr_r <= s1_addr;
    byp_data_r <= upd.wr_data;
    out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ dv/tb_synaptic_delay_event_wheel.sv @@
`timescale 1ns / 1ps

module tb_synaptic_delay_event_wheel;
  import sdew_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASE_ITEMS    = 475;
  localparam int MAX_REPORTS    = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  sdew_in_t   in_data = '0;
  logic       out_valid;
  sdew_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  // Shadow copy of the wheel state
  logic [WHEEL_SLOTS-1:0] shadow_masks [ENTRY_COUNT];
  int unsigned            shadow_slot;
  logic [7:0]             shadow_cluster;

  sdew_in_t  pending_items [$];
  sdew_out_t expected_results [$];

  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned stall_cycles = 0;
  logic [9:0]  pool_base = '0;

  synaptic_delay_event_wheel uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Apply one transaction to the shadow wheel and return its result
  function automatic sdew_out_t wheel_predict(input sdew_in_t item);
    sdew_out_t   res;
    int unsigned pos;
    int unsigned d;
    int unsigned o;
    d   = item.delay_steps;
    o   = item.step_offset;
    res = '0;
    case (item.operation)
      OP_ADD_LOCAL: begin
        if (item.target_cluster != shadow_cluster) begin
          res.forwarded       = 1'b1;
          res.fwd_entry_index = item.entry_index;
          res.fwd_cluster     = item.target_cluster;
          res.fwd_offset      = item.step_offset;
        end else if (item.entry_index >= ENTRY_COUNT || o >= WHEEL_SLOTS) begin
          res.range_error = 1'b1;
        end else begin
          pos = (shadow_slot + o) % WHEEL_SLOTS;
          res.collision = shadow_masks[item.entry_index][pos];
          shadow_masks[item.entry_index][pos] = 1'b1;
        end
      end
      OP_ADD_DELAY: begin
        if (item.entry_index >= ENTRY_COUNT || d + o >= WHEEL_SLOTS) begin
          res.range_error = 1'b1;
        end else begin
          pos = (shadow_slot + d + o) % WHEEL_SLOTS;
          res.collision = shadow_masks[item.entry_index][pos];
          shadow_masks[item.entry_index][pos] = 1'b1;
        end
      end
      OP_CHECK: begin
        if (item.entry_index >= ENTRY_COUNT || o >= WHEEL_SLOTS) begin
          res.range_error = 1'b1;
        end else begin
          pos = (shadow_slot + o) % WHEEL_SLOTS;
          res.event_found = shadow_masks[item.entry_index][pos];
          shadow_masks[item.entry_index][pos] = 1'b0;
        end
      end
      OP_CHECK_DLY: begin
        if (item.entry_index >= ENTRY_COUNT || d <= o || d >= WHEEL_SLOTS) begin
          res.range_error = 1'b1;
        end else begin
          pos = (shadow_slot + WHEEL_SLOTS - (d - o)) % WHEEL_SLOTS;
          res.event_found = shadow_masks[item.entry_index][pos];
          shadow_masks[item.entry_index][pos] = 1'b0;
        end
      end
      OP_CLEAR: begin
        if (item.entry_index >= ENTRY_COUNT)
          res.range_error = 1'b1;
        else
          shadow_masks[item.entry_index] = '0;
      end
      OP_ADVANCE: begin
        if (o >= WHEEL_SLOTS)
          res.range_error = 1'b1;
        else
          shadow_slot = (shadow_slot + o) % WHEEL_SLOTS;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Build one random transaction, mostly aimed at a small pool of entries
  function automatic sdew_in_t random_spike_op();
    sdew_in_t    item;
    int unsigned sel;
    item = sdew_in_t'({$urandom, $urandom});
    sel  = $urandom_range(99);
    if (sel < 25)      item.operation = OP_ADD_LOCAL;
    else if (sel < 45) item.operation = OP_ADD_DELAY;
    else if (sel < 62) item.operation = OP_CHECK;
    else if (sel < 77) item.operation = OP_CHECK_DLY;
    else if (sel < 83) item.operation = OP_CLEAR;
    else if (sel < 96) item.operation = OP_ADVANCE;
    else               item.operation = 3'($urandom_range(6, 7));
    if ($urandom_range(99) < 85)
      item.entry_index = pool_base ^ 10'($urandom_range(7));
    if (item.operation == OP_ADD_LOCAL && $urandom_range(99) < 75)
      item.target_cluster = shadow_cluster;
    // Keep most delayed operations inside their legal windows
    if ($urandom_range(99) < 90) begin
      if (item.operation == OP_ADD_DELAY)
        item.step_offset = 5'($urandom_range(31 - item.delay_steps));
      if (item.operation == OP_CHECK_DLY) begin
        item.delay_steps = 5'($urandom_range(1, 31));
        item.step_offset = 5'($urandom_range(item.delay_steps - 1));
      end
      if (item.operation == OP_ADVANCE)
        item.step_offset = 5'($urandom_range(3));
    end
    return item;
  endfunction

  function automatic sdew_in_t make_op(input logic [2:0] op, input logic [9:0] entry,
                                       input logic [7:0] cl, input logic [4:0] d,
                                       input logic [4:0] o);
    sdew_in_t item;
    item.operation      = op;
    item.entry_index    = entry;
    item.target_cluster = cl;
    item.delay_steps    = d;
    item.step_offset    = o;
    return item;
  endfunction

  // Wait until every queued transaction is taken and every result is back
  task automatic drain_wheel();
    while (pending_items.size() != 0 || start)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_cluster(input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shadow_cluster = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver: present the next transaction once the current one is taken
  always @(posedge clk) begin
    if (start && !busy)
      expected_results.push_back(wheel_predict(in_data));
    if (!start || !busy) begin
      if (pending_items.size() != 0 &&
          ((sent_count > 700 && sent_count < 1100) || $urandom_range(99) >= 11)) begin
        in_data <= pending_items.pop_front();
        start   <= 1'b1;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    sdew_out_t exp_res;
    if (out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h at %0t", out_data, $realtime);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.event_found     !== exp_res.event_found ||
            out_data.forwarded       !== exp_res.forwarded ||
            out_data.fwd_entry_index !== exp_res.fwd_entry_index ||
            out_data.fwd_cluster     !== exp_res.fwd_cluster ||
            out_data.fwd_offset      !== exp_res.fwd_offset ||
            out_data.collision       !== exp_res.collision ||
            out_data.range_error     !== exp_res.range_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: exp found=%b fwd=%b e=%h c=%h o=%h col=%b rerr=%b",
                     $realtime, exp_res.event_found, exp_res.forwarded,
                     exp_res.fwd_entry_index, exp_res.fwd_cluster, exp_res.fwd_offset,
                     exp_res.collision, exp_res.range_error);
          if (mismatches <= MAX_REPORTS)
            $display("                 got found=%b fwd=%b e=%h c=%h o=%h col=%b rerr=%b",
                     out_data.event_found, out_data.forwarded, out_data.fwd_entry_index,
                     out_data.fwd_cluster, out_data.fwd_offset, out_data.collision,
                     out_data.range_error);
        end
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_cluster [4];
    for (int i = 0; i < ENTRY_COUNT; i++)
      shadow_masks[i] = '0;
    shadow_slot    = 0;
    shadow_cluster = 8'd0;
    phase_cluster  = '{8'd255, 8'd0, 8'd0, 8'd0};
    phase_cluster[2] = 8'($urandom_range(1, 254));
    phase_cluster[3] = 8'($urandom_range(1, 254));

    // Hold reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation and each corner case
    write_own_cluster(8'd0);
    pending_items.push_back(make_op(OP_ADD_LOCAL, 10'd0, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_ADD_LOCAL, 10'd0, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_CHECK, 10'd0, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_CHECK, 10'd0, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_ADD_LOCAL, 10'd1023, 8'd255, 5'd31, 5'd31));
    pending_items.push_back(make_op(OP_ADD_LOCAL, 10'd1023, 8'd0, 5'd31, 5'd31));
    pending_items.push_back(make_op(OP_ADD_DELAY, 10'd5, 8'd255, 5'd31, 5'd0));
    pending_items.push_back(make_op(OP_ADD_DELAY, 10'd5, 8'd0, 5'd31, 5'd1));
    pending_items.push_back(make_op(OP_ADD_DELAY, 10'd5, 8'd0, 5'd0, 5'd31));
    pending_items.push_back(make_op(OP_ADD_DELAY, 10'd5, 8'd0, 5'd16, 5'd15));
    pending_items.push_back(make_op(OP_ADVANCE, 10'd0, 8'd0, 5'd0, 5'd31));
    pending_items.push_back(make_op(OP_CHECK_DLY, 10'd5, 8'd0, 5'd31, 5'd0));
    pending_items.push_back(make_op(OP_CHECK_DLY, 10'd5, 8'd0, 5'd5, 5'd5));
    pending_items.push_back(make_op(OP_CHECK_DLY, 10'd5, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_CHECK_DLY, 10'd1023, 8'd0, 5'd1, 5'd0));
    pending_items.push_back(make_op(OP_CHECK_DLY, 10'd1023, 8'd0, 5'd31, 5'd30));
    pending_items.push_back(make_op(OP_ADVANCE, 10'd0, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_ADVANCE, 10'd1023, 8'd255, 5'd31, 5'd1));
    pending_items.push_back(make_op(OP_CHECK, 10'd1023, 8'd0, 5'd0, 5'd31));
    pending_items.push_back(make_op(OP_CLEAR, 10'd5, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_CHECK, 10'd5, 8'd0, 5'd0, 5'd0));
    pending_items.push_back(make_op(OP_CLEAR, 10'd1023, 8'd255, 5'd31, 5'd31));
    pending_items.push_back(make_op(3'd6, 10'd1023, 8'd255, 5'd31, 5'd31));
    pending_items.push_back(make_op(3'd7, 10'd1023, 8'd255, 5'd31, 5'd31));
    drain_wheel();

    // Random phases, each under its own cluster number and entry pool
    for (int p = 0; p < 4; p++) begin
      write_own_cluster(phase_cluster[p]);
      pool_base = 10'($urandom_range(1023));
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_items.push_back(random_spike_op());
      drain_wheel();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
design/sdew_pkg.sv
design/sdew_ram.sv
design/sdew_exec.sv
design/synaptic_delay_event_wheel.sv
dv/tb_synaptic_delay_event_wheel.sv
